/* hdl/ata_san_pkg.sv */
// Package for the ATA sanitize state machine: codes, constants, the queued
// request type, the result type and the configuration register set.
// No dependencies; used by every module of the block.
`default_nettype none

package ata_san_pkg;

   // request opcodes
   localparam logic [1:0] OP_COMMAND    = 2'd0;
   localparam logic [1:0] OP_CHUNK_DONE = 2'd1;
   localparam logic [1:0] OP_TICK       = 2'd2;

   // sanitize feature codes
   localparam logic [15:0] FEAT_STATUS      = 16'h0000;
   localparam logic [15:0] FEAT_CRYPTO      = 16'h0011;
   localparam logic [15:0] FEAT_BLOCK_ERASE = 16'h0012;
   localparam logic [15:0] FEAT_OVERWRITE   = 16'h0014;
   localparam logic [15:0] FEAT_FREEZE      = 16'h0020;
   localparam logic [15:0] FEAT_ANTIFREEZE  = 16'h0040;

   // command signatures carried in the LBA field
   localparam logic [31:0] SIG_BLOCK_ERASE = 32'h426B4572;
   localparam logic [31:0] SIG_FREEZE_LOCK = 32'h46724C6B;

   // support mask bits
   localparam logic [3:0] SUP_CRYPTO      = 4'b0001;
   localparam logic [3:0] SUP_BLOCK_ERASE = 4'b0010;
   localparam logic [3:0] SUP_OVERWRITE   = 4'b0100;
   localparam logic [3:0] SUP_ANTIFREEZE  = 4'b1000;

   // abort reasons
   localparam logic [7:0] REASON_NOT_REPORTED = 8'd0;
   localparam logic [7:0] REASON_FAILED       = 8'd1;
   localparam logic [7:0] REASON_INVALID      = 8'd2;
   localparam logic [7:0] REASON_FROZEN       = 8'd3;

   // configuration register indexes
   localparam logic [1:0] CSR_MAX_LBA      = 2'd0;
   localparam logic [1:0] CSR_CHUNK_SIZE   = 2'd1;
   localparam logic [1:0] CSR_SUPPORT_MASK = 2'd2;
   localparam logic [1:0] CSR_TICK_GAP     = 2'd3;

   localparam logic [31:0] RST_MAX_LBA    = 32'd0;
   localparam logic [31:0] RST_CHUNK_SIZE = 32'h0001_0000;
   localparam logic [3:0]  RST_SUPPORT    = 4'd0;
   localparam logic [15:0] RST_TICK_GAP   = 16'd10;

   localparam logic [15:0] PROG_DONE = 16'hFFFF;
   localparam logic [15:0] TICK_MAX  = 16'hFFFF;

   // queue between front and back
   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   typedef enum logic [2:0] {
      SD0, SD1, SD2, SD3, SD4
   } sd_state_type;

   typedef enum logic [2:0] {
      KIND_NONE,
      KIND_STATUS,
      KIND_SIMPLE,
      KIND_BLOCK_ERASE,
      KIND_FREEZE,
      KIND_INVALID,
      KIND_CHUNK_DONE,
      KIND_TICK
   } item_kind_type;

   typedef enum logic [1:0] {
      RES_NONE    = 2'd0,
      RES_SUCCESS = 2'd1,
      RES_ABORT   = 2'd2
   } cmd_result_type;

   typedef struct packed {
      item_kind_type kind;
      logic [3:0]    need_mask;
      logic          key_ok;
      logic          clear_fail;
      logic          fail_mode;
      logic          chunk_failed;
   } item_type;

   typedef struct packed {
      cmd_result_type command_result;
      logic [7:0]     return_low;
      logic [7:0]     return_mid;
      logic [7:0]     sanitize_flags;
      logic           erase_issue;
      logic [31:0]    erase_start;
      logic [31:0]    erase_size;
      logic           auto_reply_enable;
      logic           save_request;
   } result_type;

   typedef struct packed {
      logic [31:0] max_lba;
      logic [31:0] chunk_size;
      logic [3:0]  support_mask;
      logic [15:0] tick_gap;
   } cfg_type;

endpackage

`default_nettype wire

/* hdl/ata_san_front.sv */
// Front stage: accepts requests, decodes opcode and feature code into a
// compact item and holds it in a register. Depends on ata_san_pkg.
`default_nettype none

module ata_san_front
   import ata_san_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_opcode,
   input  wire logic [15:0] req_feature,
   input  wire logic [31:0] req_key,
   input  wire logic [7:0]  req_count_bits,
   input  wire logic        req_security_locked,
   input  wire logic        req_chunk_failed,
   output logic             out_valid,
   input  wire logic        out_ready,
   output item_type         out_item
);

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   logic     take;

   assign req_ready = !valid_ff || out_ready;
   assign take      = req_valid && req_ready;

   always_comb begin
      item_in              = '0;
      item_in.kind         = KIND_NONE;
      item_in.clear_fail   = req_count_bits[0];
      item_in.fail_mode    = req_count_bits[4];
      item_in.chunk_failed = req_chunk_failed;
      unique case (req_opcode)
         OP_COMMAND: begin
            if (req_security_locked && req_feature != FEAT_STATUS) begin
               item_in.kind = KIND_INVALID;
            end else begin
               unique case (req_feature)
                  FEAT_STATUS: item_in.kind = KIND_STATUS;
                  FEAT_CRYPTO: begin
                     item_in.kind      = KIND_SIMPLE;
                     item_in.need_mask = SUP_CRYPTO;
                  end
                  FEAT_BLOCK_ERASE: begin
                     item_in.kind   = KIND_BLOCK_ERASE;
                     item_in.key_ok = (req_key == SIG_BLOCK_ERASE);
                  end
                  FEAT_OVERWRITE: begin
                     item_in.kind      = KIND_SIMPLE;
                     item_in.need_mask = SUP_OVERWRITE;
                  end
                  FEAT_FREEZE: begin
                     item_in.kind   = KIND_FREEZE;
                     item_in.key_ok = (req_key == SIG_FREEZE_LOCK);
                  end
                  FEAT_ANTIFREEZE: begin
                     item_in.kind      = KIND_SIMPLE;
                     item_in.need_mask = SUP_ANTIFREEZE;
                  end
                  default: item_in.kind = KIND_INVALID;
               endcase
            end
         end
         OP_CHUNK_DONE: item_in.kind = KIND_CHUNK_DONE;
         OP_TICK:       item_in.kind = KIND_TICK;
         default:       item_in.kind = KIND_NONE;
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

`default_nettype wire

/* hdl/ata_san_fifo.sv */
// Short queue of decoded items between the front and back stages.
// Depth from ata_san_pkg::Q_DEPTH. Depends on ata_san_pkg.
`default_nettype none

module ata_san_fifo
   import ata_san_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push_valid,
   output logic          push_ready,
   input  wire item_type push_item,
   output logic          pop_valid,
   input  wire logic     pop_ready,
   output item_type      pop_item
);

   item_type             slot_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]   count_ff, count_in;
   logic                 push, pop;

   assign push_ready = (count_ff != Q_CNT_W'(Q_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_item   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

/* hdl/ata_san_back.sv */
// Back stage: sanitize state machine (SD0..SD4), erase chunk scheduling and
// the registered result. Depends on ata_san_pkg.
`default_nettype none

module ata_san_back
   import ata_san_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire cfg_type  cfg,
   input  wire logic     in_valid,
   output logic          in_ready,
   input  wire item_type in_item,
   output logic          rsp_valid,
   input  wire logic     rsp_ready,
   output result_type    rsp_result
);

   sd_state_type state_ff, state_in;
   logic [15:0]  progress_ff, progress_in;
   logic         fail_mode_ff, fail_mode_in;
   logic         done_ok_ff, done_ok_in;
   logic         pending_ff, pending_in;
   logic [31:0]  chunk_start_ff, chunk_start_in;
   logic [31:0]  chunk_len_ff, chunk_len_in;
   logic [15:0]  tick_ff, tick_in;
   logic         auto_ff, auto_in;
   logic         valid_ff, valid_in;
   result_type   result_ff, result_in;

   logic         take;
   logic [47:0]  start_prod;
   logic [48:0]  start_end;
   logic [32:0]  chunk_end;

   assign in_ready = !valid_ff || rsp_ready;
   assign take     = in_valid && in_ready;

   // next chunk start and the ends used for clipping / completion
   assign start_prod = progress_ff * cfg.chunk_size;
   assign start_end  = {1'b0, start_prod} + {17'b0, cfg.chunk_size};
   assign chunk_end  = {1'b0, chunk_start_ff} + {1'b0, chunk_len_ff};

   always_comb begin
      state_in       = state_ff;
      progress_in    = progress_ff;
      fail_mode_in   = fail_mode_ff;
      done_ok_in     = done_ok_ff;
      pending_in     = pending_ff;
      chunk_start_in = chunk_start_ff;
      chunk_len_in   = chunk_len_ff;
      tick_in        = tick_ff;
      auto_in        = auto_ff;
      result_in                = '0;
      result_in.command_result = RES_NONE;
      if (take) begin
         unique case (in_item.kind)
            KIND_STATUS: begin
               if (in_item.clear_fail && !fail_mode_ff) begin
                  result_in.command_result = RES_ABORT;
                  result_in.return_low     = REASON_NOT_REPORTED;
               end else if (state_ff == SD3 && !in_item.clear_fail) begin
                  result_in.command_result = RES_ABORT;
                  result_in.return_low     = REASON_FAILED;
               end else begin
                  result_in.command_result = RES_SUCCESS;
                  result_in.return_low     = 8'hFF;
                  result_in.return_mid     = 8'hFF;
                  result_in.sanitize_flags = {done_ok_ff, 7'b0};
                  if (state_ff == SD2) begin
                     result_in.return_low        = progress_ff[7:0];
                     result_in.return_mid        = progress_ff[15:8];
                     result_in.sanitize_flags[6] = 1'b1;
                  end else if (state_ff == SD1) begin
                     result_in.sanitize_flags[5] = 1'b1;
                  end else if (state_ff == SD3) begin
                     state_in                = SD0;
                     result_in.save_request  = 1'b1;
                  end
               end
            end
            KIND_SIMPLE: begin
               if ((cfg.support_mask & in_item.need_mask) == '0) begin
                  result_in.command_result = RES_ABORT;
                  result_in.return_low     = REASON_INVALID;
               end else if (state_ff == SD1) begin
                  result_in.command_result = RES_ABORT;
                  result_in.return_low     = REASON_FROZEN;
               end else begin
                  result_in.command_result = RES_SUCCESS;
               end
            end
            KIND_BLOCK_ERASE: begin
               result_in.command_result = RES_ABORT;
               if ((cfg.support_mask & SUP_BLOCK_ERASE) == '0) begin
                  result_in.return_low = REASON_INVALID;
               end else if (state_ff == SD1) begin
                  result_in.return_low = REASON_FROZEN;
               end else if (!in_item.key_ok || state_ff == SD2) begin
                  result_in.return_low = REASON_NOT_REPORTED;
               end else if ((state_ff == SD3 || state_ff == SD4) && !fail_mode_ff &&
                            in_item.fail_mode) begin
                  // failure mode cannot be raised after a completed or failed run
                  result_in.return_low = REASON_NOT_REPORTED;
               end else begin
                  result_in.command_result = RES_SUCCESS;
                  fail_mode_in             = in_item.fail_mode;
                  state_in                 = SD2;
                  done_ok_in               = 1'b0;
                  progress_in              = '0;
                  auto_in                  = 1'b0;
                  result_in.save_request   = 1'b1;
               end
            end
            KIND_FREEZE: begin
               if (!in_item.key_ok || state_ff == SD1) begin
                  result_in.command_result = RES_ABORT;
                  result_in.return_low     = REASON_NOT_REPORTED;
               end else begin
                  result_in.command_result = RES_SUCCESS;
                  state_in                 = SD1;
                  result_in.save_request   = 1'b1;
               end
            end
            KIND_INVALID: begin
               result_in.command_result = RES_ABORT;
               result_in.return_low     = REASON_INVALID;
            end
            KIND_CHUNK_DONE: begin
               if (pending_ff) begin
                  pending_in             = 1'b0;
                  result_in.save_request = 1'b1;
                  if (in_item.chunk_failed) begin
                     state_in    = SD3;
                     auto_in     = 1'b1;
                     progress_in = PROG_DONE;
                  end else begin
                     // after a freeze lock the progress stays put
                     if (state_ff == SD2) begin
                        if (chunk_end < {1'b0, cfg.max_lba}) begin
                           progress_in = progress_ff + 16'd1;
                        end else begin
                           progress_in = PROG_DONE;
                        end
                     end
                     if (progress_in == PROG_DONE) begin
                        state_in   = SD4;
                        auto_in    = 1'b1;
                        done_ok_in = 1'b1;
                     end
                  end
               end
            end
            KIND_TICK: begin
               if (state_ff == SD2 && !pending_ff && tick_ff >= cfg.tick_gap) begin
                  if (start_prod >= {16'b0, cfg.max_lba}) begin
                     chunk_start_in = cfg.max_lba;
                     chunk_len_in   = '0;
                  end else if (start_end > {17'b0, cfg.max_lba}) begin
                     chunk_start_in = start_prod[31:0];
                     chunk_len_in   = cfg.max_lba - start_prod[31:0];
                  end else begin
                     chunk_start_in = start_prod[31:0];
                     chunk_len_in   = cfg.chunk_size;
                  end
                  pending_in            = 1'b1;
                  tick_in               = 16'd1;  // cleared, then counts this tick
                  result_in.erase_issue = 1'b1;
                  result_in.erase_start = chunk_start_in;
                  result_in.erase_size  = chunk_len_in;
               end else if (tick_ff != TICK_MAX) begin
                  tick_in = tick_ff + 16'd1;
               end
            end
            KIND_NONE: ;
            default: ;
         endcase
      end
      result_in.auto_reply_enable = auto_in;
   end

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= SD0;
         progress_ff    <= '0;
         fail_mode_ff   <= 1'b0;
         done_ok_ff     <= 1'b0;
         pending_ff     <= 1'b0;
         chunk_start_ff <= '0;
         chunk_len_ff   <= '0;
         tick_ff        <= '0;
         auto_ff        <= 1'b0;
         valid_ff       <= 1'b0;
      end else begin
         state_ff       <= state_in;
         progress_ff    <= progress_in;
         fail_mode_ff   <= fail_mode_in;
         done_ok_ff     <= done_ok_in;
         pending_ff     <= pending_in;
         chunk_start_ff <= chunk_start_in;
         chunk_len_ff   <= chunk_len_in;
         tick_ff        <= tick_in;
         auto_ff        <= auto_in;
         valid_ff       <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_result = result_ff;

endmodule

`default_nettype wire

/* hdl/ata_sanitize_state_machine.sv */
// Top level of the ATA sanitize state machine: configuration registers,
// front decode stage, item queue and back execution stage.
// Depends on ata_san_pkg, ata_san_front, ata_san_fifo, ata_san_back.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+---------------------------------------
//   req_     | req_valid / req_ready | opcode, feature, key, count_bits, ...
//   rsp_     | rsp_valid / rsp_ready | command_result ... save_request
//   csr_     | csr_valid / csr_ready | csr_index, csr_data (always ready)
//
// One request per cycle sustained while rsp_ready stays high; rsp_valid rises
// once an accepted request has passed the front register, queue slot and back
// result register. The back stage cycle holds the 16x32 chunk start multiply
// and its clip compares. Reset is synchronous; no clearing pass. A stalled
// rsp_ side fills the result register, then the queue, then the front
// register, before req_ready drops.
`default_nettype none

module ata_sanitize_state_machine
   import ata_san_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_opcode,
   input  wire logic [15:0] req_feature,
   input  wire logic [31:0] req_key,
   input  wire logic [7:0]  req_count_bits,
   input  wire logic        req_security_locked,
   input  wire logic        req_chunk_failed,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_command_result,
   output logic [7:0]       rsp_return_low,
   output logic [7:0]       rsp_return_mid,
   output logic [7:0]       rsp_sanitize_flags,
   output logic             rsp_erase_issue,
   output logic [31:0]      rsp_erase_start,
   output logic [31:0]      rsp_erase_size,
   output logic             rsp_auto_reply_enable,
   output logic             rsp_save_request,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_data
);

   cfg_type    cfg_ff, cfg_in;
   logic       front_valid, front_ready;
   item_type   front_item;
   logic       queue_valid, queue_ready;
   item_type   queue_item;
   result_type result;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MAX_LBA:      cfg_in.max_lba      = csr_data;
            CSR_CHUNK_SIZE:   cfg_in.chunk_size   = csr_data;
            CSR_SUPPORT_MASK: cfg_in.support_mask = csr_data[3:0];
            CSR_TICK_GAP:     cfg_in.tick_gap     = csr_data[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_lba      <= RST_MAX_LBA;
         cfg_ff.chunk_size   <= RST_CHUNK_SIZE;
         cfg_ff.support_mask <= RST_SUPPORT;
         cfg_ff.tick_gap     <= RST_TICK_GAP;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ata_san_front u_front (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_opcode          (req_opcode),
      .req_feature         (req_feature),
      .req_key             (req_key),
      .req_count_bits      (req_count_bits),
      .req_security_locked (req_security_locked),
      .req_chunk_failed    (req_chunk_failed),
      .out_valid           (front_valid),
      .out_ready           (front_ready),
      .out_item            (front_item)
   );

   ata_san_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_item  (front_item),
      .pop_valid  (queue_valid),
      .pop_ready  (queue_ready),
      .pop_item   (queue_item)
   );

   ata_san_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .in_valid   (queue_valid),
      .in_ready   (queue_ready),
      .in_item    (queue_item),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_result (result)
   );

   assign rsp_command_result    = result.command_result;
   assign rsp_return_low        = result.return_low;
   assign rsp_return_mid        = result.return_mid;
   assign rsp_sanitize_flags    = result.sanitize_flags;
   assign rsp_erase_issue       = result.erase_issue;
   assign rsp_erase_start       = result.erase_start;
   assign rsp_erase_size        = result.erase_size;
   assign rsp_auto_reply_enable = result.auto_reply_enable;
   assign rsp_save_request      = result.save_request;

`ifndef NO_ASSERTIONS
   // an issued chunk comes from a tick, never from a command
   a_issue_not_command : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_erase_issue) |-> (rsp_command_result == RES_NONE))
      else $error("erase chunk issued on a command response");

   // aborts carry a reason only
   a_abort_clean : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_command_result == RES_ABORT) |->
      (rsp_return_mid == 8'd0 && rsp_sanitize_flags == 8'd0 && !rsp_erase_issue))
      else $error("abort response carries progress or flags");

   // a clipped chunk never runs past the end of the user area
   a_chunk_in_range : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_erase_issue) |->
      (({1'b0, rsp_erase_start} + {1'b0, rsp_erase_size}) <= {1'b0, cfg_ff.max_lba}))
      else $error("erase chunk beyond max LBA");
`endif

endmodule

`default_nettype wire

/* sim/tb.sv */
// Testbench for ata_sanitize_state_machine: predicts every response from the
// accepted requests and checks them field by field. Depends on ata_san_pkg.
import ata_san_pkg::*;

typedef struct packed {
   logic [1:0]  opcode;
   logic [15:0] feature;
   logic [31:0] key;
   logic [7:0]  count_bits;
   logic        locked;
   logic        chunk_failed;
} request_t;

class sanitize_checker;
   logic [31:0]  max_lba;
   logic [31:0]  chunk_size;
   logic [3:0]   support_mask;
   logic [15:0]  tick_gap;
   sd_state_type sd;
   logic [15:0]  progress;
   logic         failure_mode;
   logic         done_ok;
   logic         chunk_pending;
   logic         auto_reply;
   logic [31:0]  chunk_start;
   logic [31:0]  chunk_len;
   logic [15:0]  tick_count;
   result_type   expected_replies[$];
   int           mismatches;

   function new();
      max_lba = RST_MAX_LBA;
      chunk_size = RST_CHUNK_SIZE;
      support_mask = RST_SUPPORT;
      tick_gap = RST_TICK_GAP;
      sd = SD0;
      progress = '0;
      failure_mode = 1'b0;
      done_ok = 1'b0;
      chunk_pending = 1'b0;
      auto_reply = 1'b0;
      chunk_start = '0;
      chunk_len = '0;
      tick_count = '0;
      mismatches = 0;
   endfunction

   function void write_register(logic [1:0] index, logic [31:0] data);
      case (index)
         CSR_MAX_LBA:      max_lba = data;
         CSR_CHUNK_SIZE:   chunk_size = data;
         CSR_SUPPORT_MASK: support_mask = data[3:0];
         CSR_TICK_GAP:     tick_gap = data[15:0];
         default: ;
      endcase
   endfunction

   // crypto, overwrite and antifreeze only check support and frozen state
   function void plain_command(input logic [3:0] need, output cmd_result_type res,
                               output logic [7:0] reason);
      res = RES_ABORT;
      reason = REASON_NOT_REPORTED;
      if ((support_mask & need) == 4'd0) reason = REASON_INVALID;
      else if (sd == SD1) reason = REASON_FROZEN;
      else res = RES_SUCCESS;
   endfunction

   function void note_request(request_t r);
      result_type  e;
      logic        save;
      logic [63:0] first_lba;
      e = '0;
      save = 1'b0;
      case (r.opcode)
         OP_COMMAND: begin
            e.command_result = RES_SUCCESS;
            if (r.locked && r.feature != FEAT_STATUS) begin
               e.command_result = RES_ABORT;
               e.return_low = REASON_INVALID;
            end else begin
               case (r.feature)
                  FEAT_STATUS: begin
                     if (r.count_bits[0] && !failure_mode) begin
                        e.command_result = RES_ABORT;
                        e.return_low = REASON_NOT_REPORTED;
                     end else if (sd == SD3 && !r.count_bits[0]) begin
                        e.command_result = RES_ABORT;
                        e.return_low = REASON_FAILED;
                     end else begin
                        e.return_low = 8'hFF;
                        e.return_mid = 8'hFF;
                        e.sanitize_flags = {done_ok, 7'd0};
                        if (sd == SD2) begin
                           e.return_low = progress[7:0];
                           e.return_mid = progress[15:8];
                           e.sanitize_flags[6] = 1'b1;
                        end else if (sd == SD1) begin
                           e.sanitize_flags[5] = 1'b1;
                        end else if (sd == SD3) begin
                           // status with clear-failure leaves the failed state
                           sd = SD0;
                           save = 1'b1;
                        end
                     end
                  end
                  FEAT_CRYPTO:
                     plain_command(SUP_CRYPTO, e.command_result, e.return_low);
                  FEAT_OVERWRITE:
                     plain_command(SUP_OVERWRITE, e.command_result, e.return_low);
                  FEAT_ANTIFREEZE:
                     plain_command(SUP_ANTIFREEZE, e.command_result, e.return_low);
                  FEAT_BLOCK_ERASE: begin
                     e.command_result = RES_ABORT;
                     if ((support_mask & SUP_BLOCK_ERASE) == 4'd0) begin
                        e.return_low = REASON_INVALID;
                     end else if (sd == SD1) begin
                        e.return_low = REASON_FROZEN;
                     end else if (r.key != SIG_BLOCK_ERASE || sd == SD2) begin
                        e.return_low = REASON_NOT_REPORTED;
                     end else if ((sd == SD3 || sd == SD4) && !failure_mode &&
                                  r.count_bits[4]) begin
                        e.return_low = REASON_NOT_REPORTED;
                     end else begin
                        e.command_result = RES_SUCCESS;
                        failure_mode = r.count_bits[4];
                        sd = SD2;
                        done_ok = 1'b0;
                        progress = '0;
                        auto_reply = 1'b0;
                        save = 1'b1;
                     end
                  end
                  FEAT_FREEZE: begin
                     if (r.key != SIG_FREEZE_LOCK || sd == SD1) begin
                        e.command_result = RES_ABORT;
                        e.return_low = REASON_NOT_REPORTED;
                     end else begin
                        sd = SD1;
                        save = 1'b1;
                     end
                  end
                  default: begin
                     e.command_result = RES_ABORT;
                     e.return_low = REASON_INVALID;
                  end
               endcase
            end
         end
         OP_CHUNK_DONE: begin
            if (chunk_pending) begin
               chunk_pending = 1'b0;
               if (r.chunk_failed) begin
                  sd = SD3;
                  auto_reply = 1'b1;
                  progress = PROG_DONE;
               end else begin
                  // outside SD2 (frozen mid-erase) progress stays put
                  if (sd == SD2) begin
                     if ({32'd0, chunk_start} + {32'd0, chunk_len} < {32'd0, max_lba})
                        progress = progress + 16'd1;
                     else
                        progress = PROG_DONE;
                  end
                  if (progress == PROG_DONE) begin
                     sd = SD4;
                     auto_reply = 1'b1;
                     done_ok = 1'b1;
                  end
               end
               save = 1'b1;
            end
         end
         OP_TICK: begin
            if (sd == SD2 && !chunk_pending && tick_count >= tick_gap) begin
               first_lba = {48'd0, progress} * {32'd0, chunk_size};
               tick_count = '0;
               if (first_lba >= {32'd0, max_lba}) begin
                  chunk_start = max_lba;
                  chunk_len = '0;
               end else begin
                  chunk_start = first_lba[31:0];
                  if (first_lba + {32'd0, chunk_size} > {32'd0, max_lba})
                     chunk_len = max_lba - first_lba[31:0];
                  else
                     chunk_len = chunk_size;
               end
               chunk_pending = 1'b1;
               e.erase_issue = 1'b1;
               e.erase_start = chunk_start;
               e.erase_size = chunk_len;
            end
            if (tick_count != TICK_MAX) tick_count = tick_count + 16'd1;
         end
         default: ;
      endcase
      e.auto_reply_enable = auto_reply;
      e.save_request = save;
      expected_replies.push_back(e);
   endfunction

   function void report(string msg);
      mismatches++;
      $display("%0t: %s", $time, msg);
   endfunction

   function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got)
         report($sformatf("%s mismatch: expected %0h, actual %0h", name, want, got));
   endfunction

   function void check_reply(result_type got);
      result_type want;
      if (expected_replies.size() == 0) begin
         report("response with no request outstanding");
         return;
      end
      want = expected_replies.pop_front();
      compare_field("command_result", want.command_result, got.command_result);
      compare_field("return_low", want.return_low, got.return_low);
      compare_field("return_mid", want.return_mid, got.return_mid);
      compare_field("sanitize_flags", want.sanitize_flags, got.sanitize_flags);
      compare_field("erase_issue", want.erase_issue, got.erase_issue);
      compare_field("erase_start", want.erase_start, got.erase_start);
      compare_field("erase_size", want.erase_size, got.erase_size);
      compare_field("auto_reply_enable", want.auto_reply_enable, got.auto_reply_enable);
      compare_field("save_request", want.save_request, got.save_request);
   endfunction
endclass

module tb;
   localparam logic [1:0] OP_UNUSED     = 2'd3;
   localparam logic [3:0] ALL_SUPPORTED =
      SUP_CRYPTO | SUP_BLOCK_ERASE | SUP_OVERWRITE | SUP_ANTIFREEZE;
   localparam int STALL_LIMIT = 2000;
   localparam int SETTLE_CYCLES = 8;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_opcode = OP_COMMAND;
   logic [15:0] req_feature = FEAT_STATUS;
   logic [31:0] req_key = '0;
   logic [7:0]  req_count_bits = '0;
   logic        req_security_locked = 1'b0;
   logic        req_chunk_failed = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_command_result;
   logic [7:0]  rsp_return_low;
   logic [7:0]  rsp_return_mid;
   logic [7:0]  rsp_sanitize_flags;
   logic        rsp_erase_issue;
   logic [31:0] rsp_erase_start;
   logic [31:0] rsp_erase_size;
   logic        rsp_auto_reply_enable;
   logic        rsp_save_request;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = CSR_MAX_LBA;
   logic [31:0] csr_data = '0;

   sanitize_checker sb;
   result_type      observed;
   logic            no_idle = 1'b0;
   int              stall_left = 0;
   int              quiet_cycles = 0;

   ata_sanitize_state_machine i_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_opcode            (req_opcode),
      .req_feature           (req_feature),
      .req_key               (req_key),
      .req_count_bits        (req_count_bits),
      .req_security_locked   (req_security_locked),
      .req_chunk_failed      (req_chunk_failed),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_command_result    (rsp_command_result),
      .rsp_return_low        (rsp_return_low),
      .rsp_return_mid        (rsp_return_mid),
      .rsp_sanitize_flags    (rsp_sanitize_flags),
      .rsp_erase_issue       (rsp_erase_issue),
      .rsp_erase_start       (rsp_erase_start),
      .rsp_erase_size        (rsp_erase_size),
      .rsp_auto_reply_enable (rsp_auto_reply_enable),
      .rsp_save_request      (rsp_save_request),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_data              (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int roll;
      if (no_idle) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 65) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   always @(negedge clock) begin
      if (no_idle) begin
         rsp_ready <= 1'b1;
      end else if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         stall_left <= pick_gap();
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         observed.command_result = cmd_result_type'(rsp_command_result);
         observed.return_low = rsp_return_low;
         observed.return_mid = rsp_return_mid;
         observed.sanitize_flags = rsp_sanitize_flags;
         observed.erase_issue = rsp_erase_issue;
         observed.erase_start = rsp_erase_start;
         observed.erase_size = rsp_erase_size;
         observed.auto_reply_enable = rsp_auto_reply_enable;
         observed.save_request = rsp_save_request;
         sb.check_reply(observed);
      end
   end

   // watchdog: cycles in which no channel moves anything
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_request(input request_t r);
      int gap;
      @(negedge clock);
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= r.opcode;
      req_feature <= r.feature;
      req_key <= r.key;
      req_count_bits <= r.count_bits;
      req_security_locked <= r.locked;
      req_chunk_failed <= r.chunk_failed;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(r);
   endtask

   task automatic send_command(input logic [15:0] feature, input logic [31:0] key,
                               input logic [7:0] count_bits, input logic locked);
      send_request('{OP_COMMAND, feature, key, count_bits, locked, 1'b0});
   endtask

   task automatic send_tick();
      send_request('{OP_TICK, 16'($urandom), $urandom(), 8'($urandom), 1'b0, 1'b0});
   endtask

   task automatic send_chunk_done(input logic failed);
      send_request('{OP_CHUNK_DONE, 16'($urandom), $urandom(), 8'($urandom), 1'b0, failed});
   endtask

   task automatic write_csr(input logic [1:0] index, input logic [31:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_register(index, data);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_for_replies();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.expected_replies.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic configure(input logic [31:0] lba, input logic [31:0] chunk,
                            input logic [3:0] mask, input logic [15:0] gap);
      wait_for_replies();
      write_csr(CSR_MAX_LBA, lba);
      write_csr(CSR_CHUNK_SIZE, chunk);
      write_csr(CSR_SUPPORT_MASK, {28'd0, mask});
      write_csr(CSR_TICK_GAP, {16'd0, gap});
   endtask

   // get out of SD1/SD2 through a failed chunk; assumes a small tick gap
   task automatic leave_sanitize();
      while (sb.sd == SD1 || sb.sd == SD2) begin
         if (sb.chunk_pending) send_chunk_done(1'b1);
         else send_tick();
      end
   endtask

   task automatic random_request();
      request_t r;
      int       pick;
      r.opcode = OP_COMMAND;
      r.feature = FEAT_STATUS;
      r.key = $urandom();
      r.count_bits = 8'($urandom_range(0, 255));
      r.locked = ($urandom_range(0, 9) == 0);
      r.chunk_failed = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 99);
      if (sb.sd == SD1 && sb.chunk_pending && pick < 60) begin
         r.opcode = OP_CHUNK_DONE;
      end else if (sb.sd == SD2 && pick < 85) begin
         r.locked = 1'b0;
         if (pick < 8) begin
            r.feature = FEAT_STATUS;
         end else if (pick < 12 && sb.chunk_pending) begin
            r.feature = FEAT_FREEZE;
            r.key = SIG_FREEZE_LOCK;
         end else if (sb.chunk_pending) begin
            r.opcode = OP_CHUNK_DONE;
            r.chunk_failed = ($urandom_range(0, 19) == 0);
         end else begin
            r.opcode = OP_TICK;
         end
      end else if (sb.sd != SD1 && sb.sd != SD2 && pick < 40) begin
         r.locked = 1'b0;
         r.feature = FEAT_BLOCK_ERASE;
         r.key = SIG_BLOCK_ERASE;
      end else begin
         case ($urandom_range(0, 11))
            0: r.feature = FEAT_STATUS;
            1: r.feature = FEAT_CRYPTO;
            2: begin
               r.feature = FEAT_BLOCK_ERASE;
               if ($urandom_range(0, 1)) r.key = SIG_BLOCK_ERASE;
            end
            3: r.feature = FEAT_OVERWRITE;
            4: r.feature = FEAT_FREEZE;
            5: r.feature = FEAT_ANTIFREEZE;
            6: r.feature = 16'($urandom);
            7, 8: r.opcode = OP_TICK;
            9, 10: r.opcode = OP_CHUNK_DONE;
            default: begin
               r.opcode = OP_UNUSED;
               r.feature = 16'($urandom);
            end
         endcase
      end
      // SD1 is left only by a failed chunk; a freeze without a pending chunk
      // would lock the device for the rest of the run
      if (sb.sd == SD1 && r.opcode == OP_CHUNK_DONE) r.chunk_failed = 1'b1;
      if (r.opcode == OP_COMMAND && !r.locked && r.feature == FEAT_FREEZE &&
          r.key == SIG_FREEZE_LOCK && !(sb.sd == SD2 && sb.chunk_pending))
         r.key[0] = ~r.key[0];
      send_request(r);
   endtask

   task automatic random_phase(input logic [31:0] lba, input logic [31:0] chunk,
                               input logic [3:0] mask, input logic [15:0] gap,
                               input int items);
      configure(lba, chunk, mask, gap);
      repeat (items) random_request();
   endtask

   initial begin
      sb = new();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: every feature, abort reasons, lock, ignored items, full sanitize
      configure(32'd40, 32'd30, ALL_SUPPORTED, 16'd1);
      send_command(FEAT_STATUS, 32'd0, 8'h00, 1'b0);
      send_command(FEAT_STATUS, 32'd0, 8'h01, 1'b0);
      send_command(FEAT_CRYPTO, 32'd0, 8'h00, 1'b0);
      send_command(FEAT_OVERWRITE, 32'hFFFF_FFFF, 8'hFF, 1'b1);
      send_command(FEAT_ANTIFREEZE, 32'd0, 8'h00, 1'b0);
      send_command(16'hFFFF, 32'd0, 8'h00, 1'b0);
      send_command(FEAT_STATUS, 32'd0, 8'h00, 1'b1);
      send_chunk_done(1'b0);
      send_request('{OP_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF, 1'b1, 1'b1});
      send_command(FEAT_BLOCK_ERASE, ~SIG_BLOCK_ERASE, 8'h00, 1'b0);
      send_command(FEAT_BLOCK_ERASE, SIG_BLOCK_ERASE, 8'h10, 1'b0);
      send_command(FEAT_BLOCK_ERASE, SIG_BLOCK_ERASE, 8'h10, 1'b0);
      send_tick();
      send_tick();
      send_command(FEAT_STATUS, 32'd0, 8'h00, 1'b0);
      send_command(FEAT_FREEZE, ~SIG_FREEZE_LOCK, 8'h00, 1'b0);
      send_command(FEAT_FREEZE, SIG_FREEZE_LOCK, 8'h00, 1'b0);
      send_command(FEAT_CRYPTO, 32'd0, 8'h00, 1'b0);
      send_command(FEAT_BLOCK_ERASE, SIG_BLOCK_ERASE, 8'h00, 1'b0);
      send_command(FEAT_STATUS, 32'd0, 8'h00, 1'b0);
      send_chunk_done(1'b1);
      send_command(FEAT_STATUS, 32'd0, 8'h00, 1'b0);
      send_command(FEAT_STATUS, 32'd0, 8'h01, 1'b0);
      send_command(FEAT_BLOCK_ERASE, SIG_BLOCK_ERASE, 8'h00, 1'b0);
      send_tick();
      send_chunk_done(1'b0);
      send_tick();
      send_chunk_done(1'b0);
      send_command(FEAT_STATUS, 32'd0, 8'h00, 1'b0);
      send_command(FEAT_BLOCK_ERASE, SIG_BLOCK_ERASE, 8'h10, 1'b0);

      // random, under several register settings; the sanitize in flight
      // carries over setting changes, so a chunk can be clipped to zero length at max_lba
      random_phase(32'd0, 32'd1, SUP_BLOCK_ERASE, 16'd0, 60);
      random_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, ALL_SUPPORTED, 16'd2, 60);
      no_idle = 1'b1;
      random_phase(32'hFFFF_FFFF, 32'hC000_0000, ALL_SUPPORTED, 16'd1, 60);
      no_idle = 1'b0;
      random_phase(32'd200, 32'd1000, 4'd0, 16'd0, 50);
      for (int k = 0; k < 5; k++) begin
         no_idle = (k == 2);
         random_phase(($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 400),
                      $urandom_range(1, 80),
                      4'($urandom_range(0, 15)) |
                         (($urandom_range(0, 4) != 0) ? SUP_BLOCK_ERASE : 4'd0),
                      16'($urandom_range(0, 4)), 60);
      end

      // frozen while a chunk is out: its completion leaves progress alone and
      // the device stays frozen, so this comes last
      no_idle = 1'b0;
      configure(32'd1000, 32'd10, ALL_SUPPORTED, 16'd0);
      leave_sanitize();
      send_command(FEAT_BLOCK_ERASE, SIG_BLOCK_ERASE, 8'h00, 1'b0);
      send_tick();
      send_command(FEAT_FREEZE, SIG_FREEZE_LOCK, 8'h00, 1'b0);
      send_chunk_done(1'b0);
      send_command(FEAT_STATUS, 32'd0, 8'h00, 1'b0);
      send_tick();

      wait_for_replies();
      if (sb.mismatches == 0 && sb.expected_replies.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule
